FILE: hw/rtl/rss_pkg.sv
// Shared types, codes and default sizes of the ranked sorted store.
`default_nettype none
package rss_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int KEY_BITS_DEF = 32;
	localparam int KEY_IN_W     = 32;
	localparam int INDEX_W      = 8;
	localparam int RANK_W       = 8;
	localparam int STATUS_W     = 2;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} rss_action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} rss_status_t;

	// Row commands, each already qualified by commit and success.
	typedef struct packed {
		logic ins;
		logic rem;
	} rss_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rss_if.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none
interface rss_req_if;
	import rss_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       action;
	logic signed [KEY_IN_W-1:0] key;
	logic [INDEX_W-1:0]         index;

	modport source (output valid, output action, output key, output index, input ready);
	modport sink   (input valid, input action, input key, input index, output ready);
endinterface

interface rss_rsp_if;
	import rss_pkg::*;

	logic                valid;
	logic                ready;
	logic [RANK_W-1:0]   rank;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output rank, output status, input ready);
	modport sink   (input valid, input rank, input status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rss_cell.sv
// One cell of the sorted row: holds one key, compares it and shifts.
`default_nettype none
module rss_cell #(
	parameter int KEY_BITS = rss_pkg::KEY_BITS_DEF,
	parameter int CMP_W    = 9,
	parameter int IDX      = 0
) (
	input  wire                           clk,
	input  wire rss_pkg::rss_ctl_t        ctl,
	input  wire logic signed [KEY_BITS-1:0] new_key,
	input  wire logic [CMP_W-1:0]         rm_idx,
	input  wire logic [CMP_W-1:0]         count,
	input  wire logic                     left_gt,
	input  wire logic signed [KEY_BITS-1:0] left_key,
	input  wire logic signed [KEY_BITS-1:0] right_key,
	output logic signed [KEY_BITS-1:0]    key_q,
	output logic                          gt
);
	import rss_pkg::*;

	logic occupied;
	logic past_hole;

	assign occupied  = CMP_W'(IDX) < count;
	assign gt        = occupied && (key_q > new_key);
	assign past_hole = CMP_W'(IDX) >= rm_idx;

	// Insert: greater keys stay, the first cell not greater takes the new
	// key and every cell behind it takes its left neighbour's key.
	always_ff @(posedge clk) begin
		if (ctl.ins && !gt) begin
			key_q <= left_gt ? new_key : left_key;
		end else if (ctl.rem && past_hole) begin
			key_q <= right_key;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/ranked_sorted_store.sv
// Ranked sorted store: a row of compare-and-shift cells with rank encoding.
// A word accepted into stage 1 moves on to stage 2 and then into the output register.
// Throughput: one word per cycle when the response side keeps up; the whole row
// compares and shifts as a word leaves stage 1, and the rank encoder is a stage of its own.
// Reset clears the entry count and empties the pipeline; stored keys are not cleared
// and need no clearing pass, so a word may be accepted in the first cycle after reset.
`default_nettype none
module ranked_sorted_store #(
	parameter int CAPACITY = rss_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = rss_pkg::KEY_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	rss_req_if.sink     req,
	rss_rsp_if.source   rsp
);
	import rss_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

	// Stage 1 holds the accepted word while the row works on it.
	logic                       valid_s1;
	logic                       action_s1;
	logic signed [KEY_BITS-1:0] key_s1;
	logic [INDEX_W-1:0]         index_s1;

	// Stage 2 holds the one-hot landing place and the status.
	logic                valid_s2;
	logic [CAPACITY-1:0] onehot_s2;
	rss_status_t         status_s2;

	// Output register, which keeps the response apart from the request side.
	logic                out_valid_q;
	logic [RANK_W-1:0]   rank_q;
	rss_status_t         status_q;

	logic [CNT_W-1:0] count_q;

	logic out_load;
	logic s2_free;
	logic s1_adv;
	logic is_ins;
	logic full;
	logic out_of_range;
	rss_ctl_t    ctl;
	rss_status_t status_c;
	logic [CMP_W-1:0] count_ext;
	logic [CMP_W-1:0] rm_idx;

	logic signed [KEY_BITS-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0]        gt;
	logic [CAPACITY-1:0]        onehot_c;
	logic [IDX_W-1:0]           pos_c;

	// Handshake: each stage moves on when the one after it is free or moving.
	assign out_load  = valid_s2 && (!out_valid_q || rsp.ready);
	assign s2_free   = !valid_s2 || out_load;
	assign s1_adv    = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s1_adv;

	assign rsp.valid  = out_valid_q;
	assign rsp.rank   = rank_q;
	assign rsp.status = status_q;

	// Decide the word's outcome against the current count.
	assign count_ext    = CMP_W'(count_q);
	assign rm_idx       = CMP_W'(index_s1);
	assign is_ins       = (action_s1 == ACT_INSERT);
	assign full         = (count_q == CNT_W'(CAPACITY));
	assign out_of_range = (rm_idx >= count_ext);

	always_comb begin
		ctl.ins  = s1_adv && is_ins && !full;
		ctl.rem  = s1_adv && !is_ins && !out_of_range;
		status_c = STATUS_OK;
		if (is_ins && full) begin
			status_c = STATUS_FULL;
		end else if (!is_ins && out_of_range) begin
			status_c = STATUS_RANGE;
		end
	end

	// The row of cells. Greater-than flags form a prefix because the row is
	// kept in descending order, so the landing place is where the prefix ends.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_row
		logic                       left_gt;
		logic signed [KEY_BITS-1:0] left_key;
		logic signed [KEY_BITS-1:0] right_key;

		if (i == 0) begin : g_head
			assign left_gt  = 1'b1;
			assign left_key = key_s1;
		end else begin : g_body
			assign left_gt  = gt[i-1];
			assign left_key = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_key = cell_key[i];
		end else begin : g_inner
			assign right_key = cell_key[i+1];
		end

		assign onehot_c[i] = ctl.ins && left_gt && !gt[i];

		rss_cell #(
			.KEY_BITS (KEY_BITS),
			.CMP_W    (CMP_W),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_key   (key_s1),
			.rm_idx    (rm_idx),
			.count     (count_ext),
			.left_gt   (left_gt),
			.left_key  (left_key),
			.right_key (right_key),
			.key_q     (cell_key[i]),
			.gt        (gt[i])
		);
	end

	// Rank encoder: the one-hot vector has at most one bit set, so an OR of
	// the set positions gives the landing index. Removes and failed words give zero.
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (onehot_s2[i]) begin
				pos_c = pos_c | IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (s2_free) begin
				valid_s2 <= s1_adv;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			key_s1    <= KEY_BITS'(req.key);
			index_s1  <= req.index;
		end
		if (s1_adv) begin
			onehot_s2 <= onehot_c;
			status_s2 <= status_c;
		end
		if (out_load) begin
			rank_q   <= RANK_W'(pos_c);
			status_q <= status_s2;
		end
	end

	// The count never goes beyond the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// At most one landing place is ever marked for a word held in stage 2.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0(onehot_s2))
		else $error("more than one landing place marked");

	// A committed insert grows the count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the count by one");

	// A rejected word leaves a status other than ok and marks no place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !ctl.ins && !ctl.rem) |=> (status_s2 != STATUS_OK && onehot_s2 == '0))
		else $error("rejected word reported as accepted");

endmodule
`default_nettype wire
